FILE: rtl/sds_pkg.sv
// Shared types and constants of the SCAN disk scheduler.
// Used by the request queue, the scheduling engine and the top level.
package sds_pkg;

  // Capacity of the request store and derived widths.
  localparam int unsigned MAX_REQUESTS = 32;
  localparam int unsigned CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned ADDR_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  // Field widths.
  localparam int unsigned CYL_W        = 12;
  localparam int unsigned TRAVEL_W     = 13;
  localparam int unsigned CFG_IDX_W    = 2;

  // Depth of the queue between the front and the engine.
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Reset value of the maximum cylinder register.
  localparam logic [CYL_W-1:0] MAX_CYL_RESET = 12'd199;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_POSITION    = 2'd0,
    CFG_MAX_CYLINDER     = 2'd1,
    CFG_SWEEP_TOWARD_LOW = 2'd2
  } cfg_reg_e;

  // Request class assigned by the front.
  typedef enum logic {
    REQ_PLAIN = 1'b0,
    REQ_LAST  = 1'b1
  } req_kind_e;

  // Engine states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_TRAVEL,
    ST_EMIT_RD,
    ST_EMIT_WR
  } eng_state_e;

  // One queued request.
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    req_kind_e        kind;
  } req_item_t;

  // Configuration as seen by the engine.
  typedef struct packed {
    logic [CYL_W-1:0] head_position;
    logic [CYL_W-1:0] max_cylinder;
    logic             sweep_toward_low;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [CYL_W-1:0]    served_cylinder;
    logic [TRAVEL_W-1:0] travel;
    logic                dropped;
    logic                order_end;
  } result_t;

endpackage

FILE: rtl/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler, top level with the configuration registers.
// Depends on sds_pkg; instantiates sds_queue (front) and sds_engine (back).
//
// Usage: cylinder requests enter on the in channel (valid/ready) with
// batch_end marking the last request of a batch. Requests are kept sorted in
// a store of 32 entries; a request arriving at a full store is dropped and
// the batch is flagged. On the last request the batch leaves on the out
// channel in SCAN order, one transaction per stored request, each carrying
// the sweep's head travel, the drop flag and order_end on the final one.
// Configuration (head position, maximum cylinder, sweep direction) is written
// on the cfg channel, index 0 to 2; the user must write it only while the
// block is idle, which the block itself does not enforce. A request goes
// straight into an empty store, else each larger stored entry is shifted up
// by one to make room. The final request adds a scan of the store and the
// travel computation, then one result per cycle while the receiver takes them.
// A two-entry queue in front keeps accepting requests while the engine works.
// A stalled receiver holds the output register; the engine waits on it and
// the queue fills, after which in_ready_o drops. Reset empties the queue and
// the store and loads head 0, maximum cylinder 199 and the high-end sweep.
module scan_disk_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sds_pkg::CYL_W-1:0]        cylinder_i,
  input  logic                             batch_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sds_pkg::CYL_W-1:0]        served_cylinder_o,
  output logic [sds_pkg::TRAVEL_W-1:0]     travel_o,
  output logic                             dropped_o,
  output logic                             order_end_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sds_pkg::CYL_W-1:0]        cfg_data_i
);

  sds_pkg::cfg_t      cfg_q, cfg_d;
  logic               q_valid, q_ready;
  sds_pkg::req_item_t q_item;
  sds_pkg::result_t   result;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (sds_pkg::cfg_reg_e'(cfg_index_i))
        sds_pkg::CFG_HEAD_POSITION:    cfg_d.head_position    = cfg_data_i;
        sds_pkg::CFG_MAX_CYLINDER:     cfg_d.max_cylinder     = cfg_data_i;
        sds_pkg::CFG_SWEEP_TOWARD_LOW: cfg_d.sweep_toward_low = cfg_data_i[0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_position    <= '0;
      cfg_q.max_cylinder     <= sds_pkg::MAX_CYL_RESET;
      cfg_q.sweep_toward_low <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sds_queue u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cylinder_i  (cylinder_i),
    .batch_end_i (batch_end_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  sds_engine u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign served_cylinder_o = result.served_cylinder;
  assign travel_o          = result.travel;
  assign dropped_o         = result.dropped;
  assign order_end_o       = result.order_end;

endmodule

FILE: rtl/sds_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; the read data holds its value while no read is issued.
module sds_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sds_queue.sv
// Front of the scheduler: accepts requests, classifies them and queues them.
// Depends on sds_pkg for the queued item type and the queue depth.
module sds_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sds_pkg::CYL_W-1:0]     cylinder_i,
  input  logic                          batch_end_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output sds_pkg::req_item_t            q_item_o
);

  sds_pkg::req_item_t               entry_q [sds_pkg::QUEUE_DEPTH];
  logic [sds_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [sds_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [sds_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             push, pop;
  sds_pkg::req_item_t               new_item;

  // Classify the incoming request.
  always_comb begin
    new_item.cylinder = cylinder_i;
    new_item.kind     = batch_end_i ? sds_pkg::REQ_LAST : sds_pkg::REQ_PLAIN;
  end

  assign in_ready_o = (count_q != sds_pkg::QCNT_W'(sds_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == sds_pkg::QPTR_W'(sds_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + sds_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == sds_pkg::QPTR_W'(sds_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + sds_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + sds_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - sds_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

FILE: rtl/sds_engine.sv
// Back of the scheduler: insertion into the sorted store, batch scan and emission.
// Depends on sds_pkg and instantiates sds_ram for the sorted request store.
module sds_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sds_pkg::cfg_t        cfg_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  sds_pkg::req_item_t   q_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sds_pkg::result_t     result_o
);

  localparam int unsigned CW = sds_pkg::CNT_W;
  localparam int unsigned AW = sds_pkg::ADDR_W;
  localparam int unsigned YW = sds_pkg::CYL_W;
  localparam int unsigned TW = sds_pkg::TRAVEL_W;

  sds_pkg::eng_state_e state_q, state_d;

  logic [CW-1:0]     count_q, count_d;
  logic              overflow_q, overflow_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     below_q, below_d;
  logic [CW-1:0]     k_q, k_d;
  logic [YW-1:0]     cyl_q, cyl_d;
  logic              last_q, last_d;
  logic [YW-1:0]     first_q, first_d;
  logic [YW-1:0]     top_q, top_d;
  logic [TW-1:0]     travel_q, travel_d;
  logic              out_valid_q, out_valid_d;
  sds_pkg::result_t  result_q, result_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [YW-1:0]     ram_wdata, ram_rdata;

  logic [CW-1:0]     pos_m1, pos_m2, idx_p1, n_m1, k_p1;
  logic [CW-1:0]     addr_cur, addr_nxt;
  logic              out_free;
  logic [YW-1:0]     abs_diff;
  logic [TW-1:0]     travel_calc;

  // Service-order address of the k-th result of the batch.
  function automatic logic [CW-1:0] emit_addr(input logic [CW-1:0] k,
                                               input logic [CW-1:0] n,
                                               input logic [CW-1:0] b,
                                               input logic          low);
    logic [CW-1:0] a;
    if (!low) begin
      a = (k < n - b) ? b + k : n - CW'(1) - k;
    end else begin
      a = (k < b) ? b - CW'(1) - k : k;
    end
    return a;
  endfunction

  sds_ram #(
    .WIDTH (YW),
    .DEPTH (sds_pkg::MAX_REQUESTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Common index arithmetic.
  assign pos_m1   = pos_q - CW'(1);
  assign pos_m2   = pos_q - CW'(2);
  assign idx_p1   = k_q + CW'(1);
  assign k_p1     = k_q + CW'(1);
  assign n_m1     = count_q - CW'(1);
  assign addr_cur = emit_addr(k_q, count_q, below_q, cfg_i.sweep_toward_low);
  assign addr_nxt = emit_addr(k_p1, count_q, below_q, cfg_i.sweep_toward_low);
  assign out_free = !out_valid_q || out_ready_i;

  // Head travel of the sweep, taken modulo the field width; the true value fits.
  always_comb begin
    abs_diff = (cfg_i.head_position >= cfg_i.max_cylinder) ?
               cfg_i.head_position - cfg_i.max_cylinder :
               cfg_i.max_cylinder - cfg_i.head_position;
    if (!cfg_i.sweep_toward_low) begin
      travel_calc = {1'b0, abs_diff};
      if (below_q != '0) begin
        travel_calc = travel_calc + {1'b0, cfg_i.max_cylinder} - {1'b0, first_q};
      end
    end else begin
      travel_calc = {1'b0, cfg_i.head_position};
      if (top_q > cfg_i.head_position) begin
        travel_calc = travel_calc + {1'b0, top_q};
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sds_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (count_q < CW'(sds_pkg::MAX_REQUESTS)) begin
            state_d = sds_pkg::ST_INS_RD;
          end else if (q_item_i.kind == sds_pkg::REQ_LAST) begin
            state_d = sds_pkg::ST_SCAN_RD;
          end
        end
      end
      sds_pkg::ST_INS_RD: begin
        if (pos_q == '0) begin
          state_d = last_q ? sds_pkg::ST_SCAN_RD : sds_pkg::ST_IDLE;
        end else begin
          state_d = sds_pkg::ST_INS_CMP;
        end
      end
      sds_pkg::ST_INS_CMP: begin
        if (ram_rdata > cyl_q) begin
          if (pos_m1 == '0) begin
            state_d = sds_pkg::ST_INS_RD;
          end
        end else begin
          state_d = last_q ? sds_pkg::ST_SCAN_RD : sds_pkg::ST_IDLE;
        end
      end
      sds_pkg::ST_SCAN_RD: begin
        state_d = sds_pkg::ST_SCAN_CMP;
      end
      sds_pkg::ST_SCAN_CMP: begin
        if (k_q == n_m1) begin
          state_d = sds_pkg::ST_TRAVEL;
        end
      end
      sds_pkg::ST_TRAVEL: begin
        state_d = sds_pkg::ST_EMIT_RD;
      end
      sds_pkg::ST_EMIT_RD: begin
        state_d = sds_pkg::ST_EMIT_WR;
      end
      sds_pkg::ST_EMIT_WR: begin
        if (out_free && (k_q == n_m1)) begin
          state_d = sds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sds_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output logic of each state.
  always_comb begin
    count_d     = count_q;
    overflow_d  = overflow_q;
    pos_d       = pos_q;
    below_d     = below_q;
    k_d         = k_q;
    cyl_d       = cyl_q;
    last_d      = last_q;
    first_d     = first_q;
    top_d       = top_q;
    travel_d    = travel_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_ready_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[AW-1:0];
    ram_wdata   = cyl_q;
    ram_re      = 1'b0;
    ram_raddr   = pos_m1[AW-1:0];
    unique case (state_q)
      sds_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          cyl_d   = q_item_i.cylinder;
          last_d  = (q_item_i.kind == sds_pkg::REQ_LAST);
          pos_d   = count_q;
          k_d     = '0;
          below_d = '0;
          if (count_q >= CW'(sds_pkg::MAX_REQUESTS)) begin
            overflow_d = 1'b1;
          end
        end
      end
      sds_pkg::ST_INS_RD: begin
        // Place the request at the bottom, or fetch the neighbor below it.
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
        end else begin
          ram_re = 1'b1;
        end
      end
      sds_pkg::ST_INS_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata > cyl_q) begin
          // Shift the larger entry up by one and look further down.
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          if (pos_m1 != '0) begin
            ram_re    = 1'b1;
            ram_raddr = pos_m2[AW-1:0];
          end
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      sds_pkg::ST_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_q[AW-1:0];
      end
      sds_pkg::ST_SCAN_CMP: begin
        // Count entries below the head and note the lowest and highest ones.
        if (k_q == '0) begin
          first_d = ram_rdata;
        end
        if (k_q == n_m1) begin
          top_d = ram_rdata;
          k_d   = '0;
        end else begin
          k_d       = idx_p1;
          ram_re    = 1'b1;
          ram_raddr = idx_p1[AW-1:0];
        end
        if (ram_rdata < cfg_i.head_position) begin
          below_d = below_q + CW'(1);
        end
      end
      sds_pkg::ST_TRAVEL: begin
        travel_d = travel_calc;
      end
      sds_pkg::ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_cur[AW-1:0];
      end
      sds_pkg::ST_EMIT_WR: begin
        // Load the output register and prefetch the next entry in order.
        if (out_free) begin
          out_valid_d              = 1'b1;
          result_d.served_cylinder = ram_rdata;
          result_d.travel          = travel_q;
          result_d.dropped         = overflow_q;
          result_d.order_end       = (k_q == n_m1);
          if (k_q == n_m1) begin
            count_d    = '0;
            overflow_d = 1'b0;
          end else begin
            k_d       = k_p1;
            ram_re    = 1'b1;
            ram_raddr = addr_nxt[AW-1:0];
          end
        end
      end
      default: begin
        q_ready_o = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sds_pkg::ST_IDLE;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      below_q     <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      below_q     <= below_d;
      k_q         <= k_d;
      last_q      <= last_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cyl_q    <= cyl_d;
    first_q  <= first_d;
    top_q    <= top_d;
    travel_q <= travel_d;
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
